/* hw/rtl/bpfa_pkg.sv */
// shared types and constants of the bitmap page frame allocator
package bpfa_pkg;

  localparam int DEF_MAP_BYTES  = 4096;
  localparam int DEF_PAGE_BYTES = 4096;

  localparam int OPC_W  = 2;
  localparam int ADDR_W = 27;
  localparam int BCNT_W = 28;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] RESV_RESET = 16'd512;

  typedef enum logic [OPC_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_PAGES    = 1'b0,
    CFG_RESERVED_PAGES = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_PREP,
    DP_FILL,
    DP_SCAN,
    DP_WRITE,
    DP_RESULT
  } dp_cmd_e;

  typedef struct packed {
    opcode_e op;
    logic    fill_last;
    logic    scan_hit;
    logic    scan_miss;
    logic    rmw_empty;
    logic    rmw_last;
    logic    out_valid;
  } dp_stat_t;

endpackage

/* hw/rtl/bpfa_item_if.sv */
// request channel: opcode, address and byte count
interface bpfa_item_if;
  logic                          valid;
  logic                          ready;
  logic [bpfa_pkg::OPC_W-1:0]    opcode;
  logic [bpfa_pkg::ADDR_W-1:0]   address;
  logic [bpfa_pkg::BCNT_W-1:0]   byte_count;

  modport source (output valid, opcode, address, byte_count, input ready);
  modport sink   (input valid, opcode, address, byte_count, output ready);
endinterface

/* hw/rtl/bpfa_result_if.sv */
// response channel: status and run address
interface bpfa_result_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [bpfa_pkg::ADDR_W-1:0]   run_address;

  modport source (output valid, status, run_address, input ready);
  modport sink   (input valid, status, run_address, output ready);
endinterface

/* hw/rtl/bitmap_page_frame_allocator_unit.sv */
// top level of the bitmap first-fit page frame allocator
//
//   channel   dir  beat contents
//   item_i    in   opcode, address, byte_count
//   result_o  out  status, run_address
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (total_pages, reserved_pages)
//
// one item at a time; the map is a byte-wide memory, one byte a cycle
// init: rewrites every map byte, pages below reserved_pages used; allocate: scans at most
//   min(ceil(total_pages/8), MAP_BYTES) map bytes for the first free run, then marks it used
// free: clears the range by read-modify-write, skipping it if empty; unused opcode: result only
// after reset a clearing pass over every map byte runs before the first item is taken
// a result waiting on result_o holds off the next item until it is taken
module bitmap_page_frame_allocator_unit #(
  parameter int MAP_BYTES  = bpfa_pkg::DEF_MAP_BYTES,
  parameter int PAGE_BYTES = bpfa_pkg::DEF_PAGE_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bpfa_item_if.sink                       item_i,
  bpfa_result_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bpfa_pkg::CFG_W-1:0]      cfg_data_i
);

  bpfa_pkg::dp_cmd_e  cmd;
  bpfa_pkg::dp_stat_t stat;

  bpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .in_ready_o  (item_i.ready),
    .cmd_o       (cmd)
  );

  bpfa_datapath #(
    .MAP_BYTES  (MAP_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .opcode_i      (item_i.opcode),
    .address_i     (item_i.address),
    .byte_count_i  (item_i.byte_count),
    .out_ready_i   (result_o.ready),
    .status_o      (result_o.status),
    .run_address_o (result_o.run_address),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  assign result_o.valid = stat.out_valid;

endmodule

/* hw/rtl/bpfa_ctrl.sv */
// sequencing state machine of the allocator
module bpfa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  input  bpfa_pkg::dp_stat_t stat_i,
  output logic               in_ready_o,
  output bpfa_pkg::dp_cmd_e  cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_FILL,
    ST_SCAN,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_DONE
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE) && (!stat_i.out_valid || out_ready_i);

  always_comb begin
    unique case (state_q)
      ST_CLEAR:  cmd_o = bpfa_pkg::DP_FILL;
      ST_IDLE:   cmd_o = (in_valid_i && in_ready_o) ? bpfa_pkg::DP_LOAD : bpfa_pkg::DP_NOP;
      ST_PREP:   cmd_o = bpfa_pkg::DP_PREP;
      ST_FILL:   cmd_o = bpfa_pkg::DP_FILL;
      ST_SCAN:   cmd_o = bpfa_pkg::DP_SCAN;
      ST_RMW_RD: cmd_o = bpfa_pkg::DP_NOP;
      ST_RMW_WR: cmd_o = bpfa_pkg::DP_WRITE;
      ST_DONE:   cmd_o = bpfa_pkg::DP_RESULT;
      default:   cmd_o = bpfa_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (stat_i.fill_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i && in_ready_o) state_q <= ST_PREP;
        end
        ST_PREP: begin
          unique case (stat_i.op)
            bpfa_pkg::OP_INIT:  state_q <= ST_FILL;
            bpfa_pkg::OP_ALLOC: state_q <= ST_SCAN;
            bpfa_pkg::OP_FREE:  state_q <= ST_RMW_RD;
            bpfa_pkg::OP_NONE:  state_q <= ST_DONE;
            default:            state_q <= ST_DONE;
          endcase
        end
        ST_FILL: begin
          if (stat_i.fill_last) state_q <= ST_DONE;
        end
        ST_SCAN: begin
          priority if (stat_i.scan_hit) state_q <= ST_RMW_RD;
          else if (stat_i.scan_miss)    state_q <= ST_DONE;
          else                          state_q <= ST_SCAN;
        end
        ST_RMW_RD: begin
          state_q <= stat_i.rmw_empty ? ST_DONE : ST_RMW_WR;
        end
        ST_RMW_WR: begin
          state_q <= stat_i.rmw_last ? ST_DONE : ST_RMW_RD;
        end
        ST_DONE: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/bpfa_datapath.sv */
// usage map memory, scan logic, range masks and result register
module bpfa_datapath #(
  parameter int MAP_BYTES  = bpfa_pkg::DEF_MAP_BYTES,
  parameter int PAGE_BYTES = bpfa_pkg::DEF_PAGE_BYTES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bpfa_pkg::dp_cmd_e                cmd_i,
  output bpfa_pkg::dp_stat_t               stat_o,
  input  logic [bpfa_pkg::OPC_W-1:0]       opcode_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]      address_i,
  input  logic [bpfa_pkg::BCNT_W-1:0]      byte_count_i,
  input  logic                             out_ready_i,
  output logic                             status_o,
  output logic [bpfa_pkg::ADDR_W-1:0]      run_address_o,
  input  logic                             cfg_we_i,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bpfa_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int PBW   = $clog2(PAGE_BYTES);
  localparam int MAW   = $clog2(MAP_BYTES);
  localparam int KW    = $clog2(MAP_BYTES + 1);
  localparam int PW    = KW + 3;
  localparam int CNT_W = bpfa_pkg::BCNT_W + 1 - PBW;
  localparam int SUM_W = CNT_W + 1;
  localparam int XA    = (SUM_W > PW) ? SUM_W : PW;
  localparam int XW    = (XA > bpfa_pkg::CFG_W) ? XA : bpfa_pkg::CFG_W;
  localparam int BS_W  = bpfa_pkg::BCNT_W + 1;
  localparam int TS_W  = bpfa_pkg::CFG_W + 1;

  localparam logic [XW-1:0] MAP_PAGES_X = XW'(8 * MAP_BYTES);
  localparam logic [XW-1:0] MAP_BYTES_X = XW'(MAP_BYTES);
  localparam logic [KW-1:0] LAST_BYTE   = KW'(MAP_BYTES - 1);

  localparam logic [bpfa_pkg::CFG_W-1:0] RESV_RESET_L = bpfa_pkg::RESV_RESET;

  function automatic logic [XW-1:0] umin(input logic [XW-1:0] a, input logic [XW-1:0] b);
    umin = (a < b) ? a : b;
  endfunction

  logic [7:0] mem [MAP_BYTES];

  bpfa_pkg::opcode_e               opc_q;
  logic [bpfa_pkg::ADDR_W-1:0]     addr_q;
  logic [bpfa_pkg::BCNT_W-1:0]     bcnt_q;
  logic [bpfa_pkg::CFG_W-1:0]      total_q;
  logic [bpfa_pkg::CFG_W-1:0]      resv_q;
  logic [CNT_W-1:0]                need_q;
  logic [PW-1:0]                   lo_q, hi_q;
  logic [KW-1:0]                   k_q, kd_q, kend_q;
  logic                            pv_q;
  logic                            set_q;
  logic [CNT_W-1:0]                run_q;
  logic [PW-1:0]                   start_q;
  logic [7:0]                      rdata_q;
  logic                            oval_q;
  logic                            stat_q;
  logic [bpfa_pkg::ADDR_W-1:0]     raddr_q;

  // setup arithmetic
  logic [BS_W-1:0]  bsum;
  logic [CNT_W-1:0] pg;
  logic [CNT_W-1:0] need_w;
  logic [XW-1:0]    first_x, end_x, free_hi_x, free_lo_x, init_hi_x, kend_x;
  logic [TS_W-1:0]  tsum;

  always_comb begin
    bsum    = {1'b0, bcnt_q} + BS_W'(PAGE_BYTES - 1);
    pg      = bsum[BS_W-1:PBW];
    need_w  = (pg == '0) ? CNT_W'(1) : pg;
    first_x = XW'(addr_q >> PBW);
    end_x   = first_x + XW'(pg);
    free_hi_x = umin(umin(end_x, XW'(total_q)), MAP_PAGES_X);
    if (addr_q == '0) free_hi_x = '0;
    free_lo_x = umin(first_x, free_hi_x);
    init_hi_x = umin(XW'(resv_q), MAP_PAGES_X);
    tsum      = {1'b0, total_q} + TS_W'(7);
    kend_x    = umin(XW'(tsum[TS_W-1:3]), MAP_BYTES_X);
  end

  // range mask of the current byte
  logic [7:0]    mask;
  logic [PW-1:0] mp;
  always_comb begin
    mp = '0;
    for (int b = 0; b < 8; b++) begin
      mp = {k_q, 3'(b)};
      mask[b] = (mp >= lo_q) && (mp < hi_q);
    end
  end

  // first-fit step over the eight pages of one byte
  logic [CNT_W-1:0] r;
  logic [PW-1:0]    s, p, hp;
  logic             hit, fr;
  always_comb begin
    r   = run_q;
    s   = start_q;
    hit = 1'b0;
    hp  = '0;
    p   = '0;
    fr  = 1'b0;
    for (int b = 0; b < 8; b++) begin
      p  = {kd_q, 3'(b)};
      fr = !rdata_q[b] && (XW'(p) < XW'(total_q));
      if (!hit) begin
        if (fr) begin
          if (r == '0) s = p;
          r = r + CNT_W'(1);
          if (r >= need_q) begin
            hit = 1'b1;
            hp  = p;
          end
        end else begin
          r = '0;
        end
      end
    end
  end

  logic [PW+PBW-1:0] s_bytes;
  assign s_bytes = {s, {PBW{1'b0}}};

  logic [KW-1:0] k_next;
  assign k_next = k_q + KW'(1);

  logic scan_hit, scan_miss;
  assign scan_hit  = pv_q && hit;
  assign scan_miss = !pv_q && (k_q >= kend_q);

  // memory ports
  logic       mem_we;
  logic [7:0] mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wd = mask;
    if (cmd_i == bpfa_pkg::DP_FILL) begin
      mem_we = 1'b1;
    end else if (cmd_i == bpfa_pkg::DP_WRITE) begin
      mem_we = 1'b1;
      mem_wd = set_q ? (rdata_q | mask) : (rdata_q & ~mask);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[k_q[MAW-1:0]] <= mem_wd;
    rdata_q <= mem[k_q[MAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      resv_q  <= RESV_RESET_L;
    end else if (cfg_we_i) begin
      unique case (bpfa_pkg::cfg_idx_e'(cfg_idx_i))
        bpfa_pkg::CFG_TOTAL_PAGES:    total_q <= cfg_data_i;
        bpfa_pkg::CFG_RESERVED_PAGES: resv_q  <= cfg_data_i;
        default:                      total_q <= total_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opc_q   <= bpfa_pkg::OP_NONE;
      k_q     <= '0;
      kd_q    <= '0;
      kend_q  <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      pv_q    <= 1'b0;
      set_q   <= 1'b0;
      run_q   <= '0;
      start_q <= '0;
      need_q  <= CNT_W'(1);
      oval_q  <= 1'b0;
      stat_q  <= 1'b0;
      raddr_q <= '0;
      addr_q  <= '0;
      bcnt_q  <= '0;
    end else begin
      if (cmd_i == bpfa_pkg::DP_RESULT) oval_q <= 1'b1;
      else if (out_ready_i)             oval_q <= 1'b0;

      unique case (cmd_i)
        bpfa_pkg::DP_LOAD: begin
          opc_q   <= bpfa_pkg::opcode_e'(opcode_i);
          addr_q  <= address_i;
          bcnt_q  <= byte_count_i;
          stat_q  <= 1'b0;
          raddr_q <= '0;
        end
        bpfa_pkg::DP_PREP: begin
          need_q  <= need_w;
          k_q     <= '0;
          pv_q    <= 1'b0;
          run_q   <= '0;
          start_q <= '0;
          kend_q  <= KW'(kend_x);
          set_q   <= 1'b0;
          if (opc_q == bpfa_pkg::OP_INIT) begin
            lo_q <= '0;
            hi_q <= PW'(init_hi_x);
          end else if (opc_q == bpfa_pkg::OP_FREE) begin
            lo_q <= PW'(free_lo_x);
            hi_q <= PW'(free_hi_x);
            k_q  <= KW'(free_lo_x >> 3);
          end
        end
        bpfa_pkg::DP_FILL: begin
          k_q <= (k_q == LAST_BYTE) ? '0 : k_next;
        end
        bpfa_pkg::DP_SCAN: begin
          priority if (scan_hit) begin
            lo_q    <= s;
            hi_q    <= hp + PW'(1);
            k_q     <= s[PW-1:3];
            set_q   <= 1'b1;
            raddr_q <= bpfa_pkg::ADDR_W'(s_bytes);
            pv_q    <= 1'b0;
          end else if (scan_miss) begin
            stat_q <= 1'b1;
          end else begin
            if (pv_q) begin
              run_q   <= r;
              start_q <= s;
            end
            kd_q    <= k_q;
            pv_q    <= (k_q < kend_q);
            if (k_q < kend_q) k_q <= k_next;
          end
        end
        bpfa_pkg::DP_WRITE: begin
          k_q <= k_next;
        end
        bpfa_pkg::DP_RESULT, bpfa_pkg::DP_NOP: begin
          k_q <= k_q;
        end
        default: k_q <= k_q;
      endcase
    end
  end

  always_comb begin
    stat_o.op        = opc_q;
    stat_o.fill_last = (k_q == LAST_BYTE);
    stat_o.scan_hit  = scan_hit;
    stat_o.scan_miss = scan_miss;
    stat_o.rmw_empty = (lo_q >= hi_q);
    stat_o.rmw_last  = ({k_next, 3'b000} >= hi_q);
    stat_o.out_valid = oval_q;
  end

  assign status_o      = stat_q;
  assign run_address_o = raddr_q;

endmodule
